[hw/rtl/cpr_pkg.sv]
// ----------------------------------------------------------------------------
// cpr_pkg
// Shared types and constants for the clock page replacement block.
// ----------------------------------------------------------------------------
package cpr_pkg;

   localparam int MAX_FRAMES_DEF = 8;
   localparam int PAGE_BITS_DEF  = 16;

   localparam int PAGE_W = 16;
   localparam int SLOT_W = 3;
   localparam int CNT_W  = 32;
   localparam int CSR_W  = 4;

   localparam logic [CSR_W-1:0] CSR_RESET = 4'd4;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic do_hit;
      logic do_fill;
      logic sweep_init;
      logic sweep_step;
      logic do_evict;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic hit;
      logic empty_found;
      logic ref_at_hand;
   } status_type;

endpackage

[hw/rtl/clock_page_replacement.sv]
// ----------------------------------------------------------------------------
// clock_page_replacement
// Second-chance page replacement over a small table of frames.
// ----------------------------------------------------------------------------
// A reference is taken when start is high and busy is low. A hit or a fill of
// an empty frame passes LOOKUP and the rsp_valid register before the rsp_valid
// strobe. When all frames in use are full, the clock hand sweeps one frame per
// cycle in the SWEEP state, clearing set reference bits, and evicts at the
// first clear bit; it clears at most as many bits as there are frames in use.
// rsp_valid is high for exactly one cycle and the receiver cannot stall it;
// the result fields are only meaningful in that cycle, except the hit and
// miss totals, which always show the current counts. The frame count register
// is written through csr_valid / csr_ready, ready only while the block is idle.
module clock_page_replacement #(
   parameter int MAX_FRAMES = cpr_pkg::MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = cpr_pkg::PAGE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [cpr_pkg::PAGE_W-1:0] req_page_number,
   output logic                       rsp_valid,
   output logic                       rsp_hit,
   output logic [cpr_pkg::SLOT_W-1:0] rsp_frame_slot,
   output logic                       rsp_evicted_valid,
   output logic [cpr_pkg::PAGE_W-1:0] rsp_evicted_page,
   output logic [cpr_pkg::CNT_W-1:0]  rsp_hit_total,
   output logic [cpr_pkg::CNT_W-1:0]  rsp_miss_total,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [cpr_pkg::CSR_W-1:0]  csr_data
);
   import cpr_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = !busy;

   cpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   cpr_dp #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write         (csr_valid && csr_ready),
      .csr_data          (csr_data),
      .page_number       (req_page_number),
      .rsp_hit           (rsp_hit),
      .rsp_frame_slot    (rsp_frame_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_hit_total     (rsp_hit_total),
      .rsp_miss_total    (rsp_miss_total)
   );

   // a transaction always ends with the block idle again
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // a result only follows a cycle of work
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> $past(busy))
      else $error("result strobe without a preceding transaction");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not start");

   // an eviction is always a miss, and a hit is always counted
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted_valid) |-> (!rsp_hit && rsp_miss_total != '0))
      else $error("eviction reported on a hit");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_hit_total != '0))
      else $error("hit not counted");

endmodule

[hw/rtl/cpr_ctrl.sv]
// ----------------------------------------------------------------------------
// cpr_ctrl
// Sequencer: lookup, optional hand sweep, then one result strobe.
// ----------------------------------------------------------------------------
module cpr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  cpr_pkg::status_type status,
   output cpr_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);
   import cpr_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      LOOKUP,
      SWEEP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = LOOKUP;
            end
         end
         LOOKUP: begin
            if (status.hit) begin
               cmd.do_hit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end else if (status.empty_found) begin
               cmd.do_fill  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end else begin
               cmd.sweep_init = 1'b1;
               state_in       = SWEEP;
            end
         end
         SWEEP: begin
            // second chance: clear and move on until a clear bit is found
            if (status.ref_at_hand) begin
               cmd.sweep_step = 1'b1;
            end else begin
               cmd.do_evict = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[hw/rtl/cpr_dp.sv]
// ----------------------------------------------------------------------------
// cpr_dp
// Frame table, clock hand, counters, frame count register and result registers.
// ----------------------------------------------------------------------------
module cpr_dp #(
   parameter int MAX_FRAMES = cpr_pkg::MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = cpr_pkg::PAGE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cpr_pkg::cmd_type           cmd,
   output cpr_pkg::status_type        status,
   input  logic                       csr_write,
   input  logic [cpr_pkg::CSR_W-1:0]  csr_data,
   input  logic [cpr_pkg::PAGE_W-1:0] page_number,
   output logic                       rsp_hit,
   output logic [cpr_pkg::SLOT_W-1:0] rsp_frame_slot,
   output logic                       rsp_evicted_valid,
   output logic [cpr_pkg::PAGE_W-1:0] rsp_evicted_page,
   output logic [cpr_pkg::CNT_W-1:0]  rsp_hit_total,
   output logic [cpr_pkg::CNT_W-1:0]  rsp_miss_total
);
   import cpr_pkg::*;

   localparam int SW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int PW   = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
   localparam int CMPW = (SW + 1 > CSR_W) ? SW + 1 : CSR_W;

   logic [MAX_FRAMES-1:0] valid_ff;
   logic [MAX_FRAMES-1:0] ref_ff;
   logic [PW-1:0]         frame_page_ff [MAX_FRAMES];
   logic [PW-1:0]         page_ff;
   logic [SW-1:0]         hand_ff;
   logic [CNT_W-1:0]      hit_cnt_ff;
   logic [CNT_W-1:0]      miss_cnt_ff;
   logic [CSR_W-1:0]      fiu_ff;

   logic                  hit_ff;
   logic [SW-1:0]         slot_ff;
   logic                  evicted_ff;
   logic [PW-1:0]         evicted_page_ff;

   logic [CSR_W-1:0]      n_active;
   logic [MAX_FRAMES-1:0] in_range;
   logic [MAX_FRAMES-1:0] match;
   logic [MAX_FRAMES-1:0] empty;
   logic [SW-1:0]         match_idx;
   logic [SW-1:0]         empty_idx;
   logic [SW-1:0]         hand_next;
   logic [SW-1:0]         hand_start;

   // out-of-range frame counts clamp to one and to the table size
   always_comb begin
      if (fiu_ff == '0) begin
         n_active = CSR_W'(1);
      end else if (int'(fiu_ff) > MAX_FRAMES) begin
         n_active = CSR_W'(MAX_FRAMES);
      end else begin
         n_active = fiu_ff;
      end
   end

   // parallel match and lowest empty frame
   always_comb begin
      match_idx = '0;
      empty_idx = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         in_range[i] = (i < int'(n_active));
         match[i]    = in_range[i] && valid_ff[i] && (frame_page_ff[i] == page_ff);
         empty[i]    = in_range[i] && !valid_ff[i];
      end
      for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
         if (match[i]) begin
            match_idx = SW'(i);
         end
         if (empty[i]) begin
            empty_idx = SW'(i);
         end
      end
   end

   always_comb begin
      hand_next  = (CMPW'(hand_ff) + CMPW'(1) >= CMPW'(n_active)) ? '0 : hand_ff + SW'(1);
      hand_start = (CMPW'(hand_ff) >= CMPW'(n_active)) ? '0 : hand_ff;
   end

   assign status.hit         = |match;
   assign status.empty_found = |empty;
   assign status.ref_at_hand = ref_ff[hand_ff];

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         ref_ff      <= '0;
         hand_ff     <= '0;
         hit_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
         fiu_ff      <= CSR_RESET;
      end else begin
         if (csr_write) begin
            fiu_ff <= csr_data;
         end
         if (cmd.do_hit) begin
            ref_ff[match_idx] <= 1'b1;
            if (hit_cnt_ff != '1) begin
               hit_cnt_ff <= hit_cnt_ff + CNT_W'(1);
            end
         end
         if (cmd.do_fill) begin
            valid_ff[empty_idx] <= 1'b1;
            ref_ff[empty_idx]   <= 1'b1;
         end
         if (cmd.sweep_init) begin
            hand_ff <= hand_start;
         end
         if (cmd.sweep_step) begin
            ref_ff[hand_ff] <= 1'b0;
            hand_ff         <= hand_next;
         end
         if (cmd.do_evict) begin
            valid_ff[hand_ff] <= 1'b1;
            ref_ff[hand_ff]   <= 1'b1;
         end
         if ((cmd.do_fill || cmd.do_evict) && miss_cnt_ff != '1) begin
            miss_cnt_ff <= miss_cnt_ff + CNT_W'(1);
         end
      end
   end

   // payload: page table and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff <= page_number[PW-1:0];
      end
      if (cmd.do_hit) begin
         hit_ff          <= 1'b1;
         slot_ff         <= match_idx;
         evicted_ff      <= 1'b0;
         evicted_page_ff <= '0;
      end
      if (cmd.do_fill) begin
         frame_page_ff[empty_idx] <= page_ff;
         hit_ff                   <= 1'b0;
         slot_ff                  <= empty_idx;
         evicted_ff               <= 1'b0;
         evicted_page_ff          <= '0;
      end
      if (cmd.do_evict) begin
         frame_page_ff[hand_ff] <= page_ff;
         hit_ff                 <= 1'b0;
         slot_ff                <= hand_ff;
         evicted_ff             <= 1'b1;
         evicted_page_ff        <= frame_page_ff[hand_ff];
      end
   end

   assign rsp_hit           = hit_ff;
   assign rsp_frame_slot    = SLOT_W'(slot_ff);
   assign rsp_evicted_valid = evicted_ff;
   assign rsp_evicted_page  = PAGE_W'(evicted_page_ff);
   assign rsp_hit_total     = hit_cnt_ff;
   assign rsp_miss_total    = miss_cnt_ff;

endmodule

[sim/cpr_checker.sv]
// ----------------------------------------------------------------------------
// cpr_checker
// Watches the reference, result and frame count channels of the clock page
// replacement block, keeps its own copy of the frame table, clock hand and
// hit/miss totals, and compares every result strobe with the oldest
// predicted result.
// ----------------------------------------------------------------------------
module cpr_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic [cpr_pkg::PAGE_W-1:0] req_page_number,
   input  logic                       rsp_valid,
   input  logic                       rsp_hit,
   input  logic [cpr_pkg::SLOT_W-1:0] rsp_frame_slot,
   input  logic                       rsp_evicted_valid,
   input  logic [cpr_pkg::PAGE_W-1:0] rsp_evicted_page,
   input  logic [cpr_pkg::CNT_W-1:0]  rsp_hit_total,
   input  logic [cpr_pkg::CNT_W-1:0]  rsp_miss_total,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [cpr_pkg::CSR_W-1:0]  csr_data,
   output int                         results_seen,
   output int                         failures
);
   timeunit 1ns;
   timeprecision 1ps;
   import cpr_pkg::*;

   localparam int FRAMES           = MAX_FRAMES_DEF;
   localparam int SHOWN_MISMATCHES = 10;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] frame_slot;
      logic              evicted_valid;
      logic [PAGE_W-1:0] evicted_page;
      logic [CNT_W-1:0]  hit_total;
      logic [CNT_W-1:0]  miss_total;
   } page_result_type;

   logic              frame_used [FRAMES];
   logic [PAGE_W-1:0] frame_tag  [FRAMES];
   logic              ref_mark   [FRAMES];
   int                hand;
   logic [CNT_W-1:0]  hit_count;
   logic [CNT_W-1:0]  miss_count;
   logic [CSR_W-1:0]  frame_count_reg;
   page_result_type   pending_results[$];
   int                mismatch_count = 0;

   task automatic predict_reference(input logic [PAGE_W-1:0] page,
                                    output page_result_type res);
      int                n;
      int                i;
      int                k;
      int                h;
      int                slot;
      int                empty_slot;
      bit                found;
      bit                has_empty;
      bit                evicted;
      logic [PAGE_W-1:0] old_page;
      // zero acts as one frame, anything above the table size as the table size
      n = (frame_count_reg == '0) ? 1 :
          ((frame_count_reg > FRAMES) ? FRAMES : int'(frame_count_reg));
      found      = 1'b0;
      has_empty  = 1'b0;
      evicted    = 1'b0;
      slot       = 0;
      empty_slot = 0;
      old_page   = '0;
      for (i = 0; i < n; i++) begin
         if (!found && frame_used[i] && frame_tag[i] == page) begin
            found = 1'b1;
            slot  = i;
         end
      end
      if (!found) begin
         for (i = 0; i < n; i++) begin
            if (!has_empty && !frame_used[i]) begin
               has_empty  = 1'b1;
               empty_slot = i;
            end
         end
      end
      if (found) begin
         ref_mark[slot] = 1'b1;
         if (hit_count != '1) hit_count++;
      end else begin
         if (has_empty) begin
            slot = empty_slot;
         end else begin
            h = (hand >= n) ? 0 : hand;
            // give every marked frame a second chance on the way round
            for (k = 0; k < 2 * FRAMES + 2 && ref_mark[h]; k++) begin
               ref_mark[h] = 1'b0;
               h = (h + 1 >= n) ? 0 : h + 1;
            end
            slot     = h;
            evicted  = 1'b1;
            old_page = frame_tag[h];
            hand     = h;
         end
         frame_used[slot] = 1'b1;
         frame_tag[slot]  = page;
         ref_mark[slot]   = 1'b1;
         if (miss_count != '1) miss_count++;
      end
      res.hit           = found;
      res.frame_slot    = slot[SLOT_W-1:0];
      res.evicted_valid = evicted;
      res.evicted_page  = old_page;
      res.hit_total     = hit_count;
      res.miss_total    = miss_count;
   endtask

   always @(posedge clock) begin
      page_result_type predicted;
      page_result_type oldest;
      bit              bad;
      if (reset) begin
         for (int i = 0; i < FRAMES; i++) begin
            frame_used[i] = 1'b0;
            frame_tag[i]  = '0;
            ref_mark[i]   = 1'b0;
         end
         hand            = 0;
         hit_count       = '0;
         miss_count      = '0;
         frame_count_reg = CSR_RESET;
         pending_results.delete();
         results_seen <= 0;
      end else begin
         if (csr_valid && csr_ready) frame_count_reg = csr_data;
         if (rsp_valid) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= SHOWN_MISMATCHES)
                  $display("%0t: result with no outstanding reference (slot %0d)",
                           $time, rsp_frame_slot);
            end else begin
               oldest = pending_results.pop_front();
               bad = (rsp_hit !== oldest.hit) ||
                     (rsp_frame_slot !== oldest.frame_slot) ||
                     (rsp_evicted_valid !== oldest.evicted_valid) ||
                     (rsp_evicted_page !== oldest.evicted_page) ||
                     (rsp_hit_total !== oldest.hit_total) ||
                     (rsp_miss_total !== oldest.miss_total);
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= SHOWN_MISMATCHES) begin
                     $display("%0t: expected hit=%0d slot=%0d evict=%0d page=%h hits=%0d misses=%0d",
                              $time, oldest.hit, oldest.frame_slot, oldest.evicted_valid,
                              oldest.evicted_page, oldest.hit_total, oldest.miss_total);
                     $display("%0t:   actual hit=%0d slot=%0d evict=%0d page=%h hits=%0d misses=%0d",
                              $time, rsp_hit, rsp_frame_slot, rsp_evicted_valid,
                              rsp_evicted_page, rsp_hit_total, rsp_miss_total);
                  end
               end
            end
         end
         if (start && !busy) begin
            predict_reference(req_page_number, predicted);
            pending_results = {pending_results, predicted};
         end
      end
      failures <= mismatch_count + pending_results.size();
   end

endmodule

[sim/clock_page_replacement_tb.sv]
// ----------------------------------------------------------------------------
// clock_page_replacement_tb
// Drives page references and frame count writes into the clock page
// replacement block: a directed pass over fills, hits, evictions and the odd
// frame counts, then random working sets under several frame counts with
// bursts of idle cycles in most phases. The checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module clock_page_replacement_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cpr_pkg::*;

   localparam time CLK_PERIOD   = 10ns;
   localparam int  RESET_CYCLES = 8;
   localparam int  CYCLE_LIMIT  = 200000;
   localparam int  DRAIN_CYCLES = 20;
   localparam int  PHASES       = 12;
   localparam int  PHASE_ITEMS  = 125;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [PAGE_W-1:0] req_page_number = '0;
   logic              rsp_valid;
   logic              rsp_hit;
   logic [SLOT_W-1:0] rsp_frame_slot;
   logic              rsp_evicted_valid;
   logic [PAGE_W-1:0] rsp_evicted_page;
   logic [CNT_W-1:0]  rsp_hit_total;
   logic [CNT_W-1:0]  rsp_miss_total;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_data = '0;

   int results_seen;
   int failures;
   int items_sent  = 0;
   int cycle_count = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   clock_page_replacement i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_frame_slot    (rsp_frame_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_hit_total     (rsp_hit_total),
      .rsp_miss_total    (rsp_miss_total),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   cpr_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_frame_slot    (rsp_frame_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_hit_total     (rsp_hit_total),
      .rsp_miss_total    (rsp_miss_total),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .results_seen      (results_seen),
      .failures          (failures)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // start stays high across back-to-back transactions, it only drops for a gap
   task automatic issue_reference(input logic [PAGE_W-1:0] page, input int idle_pct);
      int gap;
      if (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
         gap = $urandom_range(8, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_page_number <= page;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // the frame count only changes once every outstanding result is back
   task automatic write_frame_count(input logic [CSR_W-1:0] value);
      start <= 1'b0;
      while (results_seen != items_sent) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [PAGE_W-1:0] page_pool[$];
      logic [PAGE_W-1:0] page;
      logic [CSR_W-1:0]  frame_count;
      int                idle_pct;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // four frames after reset: fill, hit, then a full sweep
      issue_reference(16'h0000, 0);
      issue_reference(16'hFFFF, 0);
      issue_reference(16'h0001, 0);
      issue_reference(16'h0000, 0);
      issue_reference(16'hFFFF, 0);
      issue_reference(16'h8000, 0);
      issue_reference(16'h1234, 0);
      issue_reference(16'h5555, 0);
      issue_reference(16'hAAAA, 0);
      // count above the table acts as the full table
      write_frame_count(4'd15);
      issue_reference(16'h7FFF, 0);
      issue_reference(16'h0002, 0);
      issue_reference(16'h0003, 0);
      issue_reference(16'h0004, 0);
      issue_reference(16'h0008, 0);
      // shrink below the hand, upper frames keep their pages
      write_frame_count(4'd2);
      issue_reference(16'h4321, 0);
      issue_reference(16'h0004, 0);
      // zero acts as a single frame
      write_frame_count(4'd0);
      issue_reference(16'h0000, 0);
      issue_reference(16'h00FF, 0);
      write_frame_count(4'd9);
      issue_reference(16'h0003, 0);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: frame_count = 4'd1;
            1: frame_count = 4'd8;
            2: frame_count = 4'd0;
            3: frame_count = 4'd15;
            default: frame_count = CSR_W'($urandom_range(15, 0));
         endcase
         write_frame_count(frame_count);
         // a small working set per phase gives a mix of hits and evictions
         page_pool.delete();
         repeat ($urandom_range(11, 2)) page_pool = {page_pool, PAGE_W'($urandom())};
         idle_pct = (phase == PHASES - 1 || phase % 3 == 2) ? 0 : 30;
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(99, 0) < 20)
               page = PAGE_W'($urandom());
            else
               page = page_pool[$urandom_range(page_pool.size() - 1, 0)];
            issue_reference(page, idle_pct);
         end
      end

      start <= 1'b0;
      while (results_seen != items_sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/cpr_pkg.sv
hw/rtl/cpr_ctrl.sv
hw/rtl/cpr_dp.sv
hw/rtl/clock_page_replacement.sv
sim/cpr_checker.sv
sim/clock_page_replacement_tb.sv
